[hw/rtl/rrr_pkg.sv]
`default_nettype none
package rrr_pkg;

  // Width of a refractive index field, unsigned Q4.12
  localparam int IDX_W = 16;

  typedef enum logic {
    ACT_REFRACT = 1'b0,
    ACT_REFLECT = 1'b1
  } action_t;

endpackage
`default_nettype wire

[hw/rtl/rrr_delay.sv]
`default_nettype none
module rrr_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d_in,
  output logic      [WIDTH-1:0] d_out
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_in;
      for (int k = 1; k < DEPTH; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign d_out = sr_r[DEPTH-1];

endmodule
`default_nettype wire

[hw/rtl/rrr_sqrt.sv]
`default_nettype none
// Pipelined integer square root, one result bit per stage, floor(sqrt(radicand)).
module rrr_sqrt #(
  parameter int IN_W = 50
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [IN_W-1:0]   radicand,
  output logic      [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW    = OUT_W + 2;

  logic [RW-1:0]    rem_r   [OUT_W];
  logic [OUT_W-1:0] root_r  [OUT_W];
  logic [IN_W-1:0]  rad_r   [OUT_W];

  logic [RW-1:0]    rem_in   [OUT_W];
  logic [OUT_W-1:0] root_in  [OUT_W];
  logic [IN_W-1:0]  rad_in   [OUT_W];
  logic [RW-1:0]    rem_nxt  [OUT_W];
  logic [OUT_W-1:0] root_nxt [OUT_W];
  logic [IN_W-1:0]  rad_nxt  [OUT_W];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = radicand;
    for (int s = 1; s < OUT_W; s++) begin
      rem_in[s]  = rem_r[s-1];
      root_in[s] = root_r[s-1];
      rad_in[s]  = rad_r[s-1];
    end
  end

  always_comb begin
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    for (int s = 0; s < OUT_W; s++) begin
      r2    = {rem_in[s][OUT_W-1:0], rad_in[s][IN_W-1:IN_W-2]};
      trial = {root_in[s], 2'b01};
      if (r2 >= trial) begin
        rem_nxt[s]  = r2 - trial;
        root_nxt[s] = {root_in[s][OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = r2;
        root_nxt[s] = {root_in[s][OUT_W-2:0], 1'b0};
      end
      rad_nxt[s] = {rad_in[s][IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < OUT_W; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        rad_r[s]  <= rad_nxt[s];
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule
`default_nettype wire

[hw/rtl/rrr_div.sv]
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The upper DW bits of the dividend must be below the divisor.
module rrr_div #(
  parameter int DW = 16,
  parameter int QW = 24
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DW+QW-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic      [QW-1:0]    quotient
);

  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [DW-1:0] dv_r    [QW];

  logic [DW-1:0] rem_in  [QW];
  logic [QW-1:0] low_in  [QW];
  logic [DW-1:0] dv_in   [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];

  always_comb begin
    rem_in[0] = dividend[DW+QW-1:QW];
    low_in[0] = dividend[QW-1:0];
    dv_in[0]  = divisor;
    for (int s = 1; s < QW; s++) begin
      rem_in[s] = rem_r[s-1];
      low_in[s] = low_r[s-1];
      dv_in[s]  = dv_r[s-1];
    end
  end

  always_comb begin
    logic [DW:0] r2;
    logic [DW:0] diff;
    for (int s = 0; s < QW; s++) begin
      r2   = {rem_in[s], low_in[s][QW-1]};
      diff = r2 - {1'b0, dv_in[s]};
      if (r2 >= {1'b0, dv_in[s]}) begin
        rem_nxt[s] = diff[DW-1:0];
        low_nxt[s] = {low_in[s][QW-2:0], 1'b1};
      end else begin
        rem_nxt[s] = r2[DW-1:0];
        low_nxt[s] = {low_in[s][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        dv_r[s]  <= dv_in[s];
      end
    end
  end

  assign quotient = low_r[QW-1];

endmodule
`default_nettype wire

[hw/rtl/ray_refract_reflect.sv]
// Throughput: one ray per cycle; the whole pipeline advances when the output
// register is empty or taken. Depth is set by two bit-per-stage square roots in
// series (length, then the new normal root) and three bit-per-stage divider banks
// (direction normalize, index ratio, normal-part normalize).
// Reset (rst_n low, synchronous) clears the stage valid bits only.
`default_nettype none
module ray_refract_reflect #(
  parameter int COMP_WIDTH = 24,
  parameter int FRAC_BITS  = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to
  input  wire logic [((6*COMP_WIDTH+2*rrr_pkg::IDX_W+7)/8)*8-1:0] in_tdata,
  // action
  input  wire logic in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // out_x, out_y, out_z
  output logic [((3*COMP_WIDTH+7)/8)*8-1:0] out_tdata,
  // passed
  output logic      out_tuser
);

  localparam int W   = COMP_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int IW  = rrr_pkg::IDX_W;
  localparam int LW  = W + 1;
  localparam int SQW = 2 * W + 2;
  localparam int PW  = 2 * W;
  localparam int PW2 = 2 * W + 2;
  localparam int SXW = 2 * W + 4;
  localparam int QX  = W + F + 2;
  localparam int QDW = LW + F + 1;

  localparam int T_LEN = 2 + LW;
  localparam int T_U   = T_LEN + F + 2;
  localparam int T_T   = T_U + 4;
  localparam int T_S   = T_T + W + 2;
  localparam int T_R   = T_S + 2 + LW;
  localparam int T_CU  = T_R + F + 2;
  localparam int LAT   = T_CU + 4;

  localparam logic signed [W-1:0]   CMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   CMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SXW-1:0] CMAX_X = SXW'(CMAX);
  localparam logic signed [SXW-1:0] CMIN_X = SXW'(CMIN);
  localparam logic [QX-1:0]         HALF   = QX'(1) << (W - 1);
  localparam logic [SQW-1:0]        ONE2   = SQW'(1) << (2 * F);

  function automatic logic signed [W-1:0] sat_w(input logic signed [SXW-1:0] v);
    if (v > CMAX_X) return CMAX;
    else if (v < CMIN_X) return CMIN;
    else return v[W-1:0];
  endfunction

  function automatic logic signed [SXW-1:0] sx(input logic signed [W-1:0] v);
    logic signed [SXW-1:0] x;
    x = v;
    return x;
  endfunction

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    logic [W-1:0] m;
    m = v;
    return v[W-1] ? (~m + 1'b1) : m;
  endfunction

  function automatic logic signed [SXW-1:0] fl_x(input logic signed [PW2-1:0] p);
    logic signed [SXW-1:0] x;
    x = p;
    return x >>> F;
  endfunction

  function automatic logic signed [W-1:0] fl_sat(input logic signed [PW2-1:0] p);
    return sat_w(fl_x(p));
  endfunction

  function automatic logic signed [W-1:0] dot_sat(input logic signed [PW2-1:0] a,
                                                  input logic signed [PW2-1:0] b,
                                                  input logic signed [PW2-1:0] c);
    return sat_w(fl_x(a) + fl_x(b) + fl_x(c));
  endfunction

  function automatic logic signed [PW2-1:0] smul(input logic signed [W-1:0] a,
                                                 input logic signed [W+1:0] b);
    logic signed [PW2-1:0] ax;
    logic signed [PW2-1:0] bx;
    ax = a;
    bx = b;
    return ax * bx;
  endfunction

  // Apply sign to a magnitude quotient, clamping at the component range
  function automatic logic signed [W-1:0] clamp_q(input logic [QX-1:0] q,
                                                  input logic neg, input logic zero);
    logic [W-1:0] m;
    m = q[W-1:0];
    if (zero) return '0;
    else if (q >= HALF) return neg ? CMIN : CMAX;
    else return neg ? (~m + 1'b1) : m;
  endfunction

  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------- front: squares and products ----------------
  logic [2:0][W-1:0]   in_dir, in_nrm;
  logic [IW-1:0]       in_from, in_to;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_dir[i] = in_tdata[i*W +: W];
      in_nrm[i] = in_tdata[(3+i)*W +: W];
    end
    in_from = in_tdata[6*W +: IW];
    in_to   = in_tdata[6*W+IW +: IW];
  end

  logic [2:0][W-1:0]   d1_r, n1_r;
  logic                act1_r;
  logic [IW-1:0]       from1_r, to1_r;
  logic [2:0][PW-1:0]  sq1_r;
  logic [2:0][PW2-1:0] dn1_r;
  logic [SQW-1:0]      l2_r;
  logic [W-1:0]        p2_r;
  logic [2:0][W-1:0]   n2, d3;
  logic [2:0][PW2-1:0] rp3_r;
  logic [2:0][W-1:0]   rr4_r;

  rrr_delay #(.WIDTH(3*W), .DEPTH(1)) u_dly_n2 (.clk, .en, .d_in(n1_r), .d_out(n2));
  rrr_delay #(.WIDTH(3*W), .DEPTH(2)) u_dly_d3 (.clk, .en, .d_in(d1_r), .d_out(d3));

  // ---------------- length and normalize ----------------
  logic [LW-1:0]       len;
  logic [2:0][W-1:0]   d_len;
  logic [2:0][QDW-1:0] u_dvd;
  logic [2:0][F:0]     u_q;
  logic [3:0]          u_sb_in, u_sb;
  logic [2:0][W-1:0]   u_r, n_u, n_u2, u_u3;
  logic [2:0][PW2-1:0] un_r, ndn_r;
  logic [W-1:0]        dnu_r;

  rrr_sqrt #(.IN_W(SQW)) u_sqrt_len (.clk, .en, .radicand(l2_r), .root(len));

  rrr_delay #(.WIDTH(3*W), .DEPTH(T_LEN-1)) u_dly_dlen (
    .clk, .en, .d_in(d1_r), .d_out(d_len));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_dvd[i]   = QDW'({mag_w(d_len[i]), {F{1'b0}}});
      u_sb_in[i] = d_len[i][W-1];
    end
    u_sb_in[3] = (len == '0);
  end

  for (genvar g = 0; g < 3; g++) begin : g_udiv
    rrr_div #(.DW(LW), .QW(F+1)) u_div (
      .clk, .en, .dividend(u_dvd[g]), .divisor(len), .quotient(u_q[g]));
  end

  rrr_delay #(.WIDTH(4), .DEPTH(F+1)) u_dly_usb (.clk, .en, .d_in(u_sb_in), .d_out(u_sb));
  rrr_delay #(.WIDTH(3*W), .DEPTH(T_U-1)) u_dly_nu (.clk, .en, .d_in(n1_r), .d_out(n_u));
  rrr_delay #(.WIDTH(3*W), .DEPTH(2)) u_dly_nu2 (.clk, .en, .d_in(n_u), .d_out(n_u2));
  rrr_delay #(.WIDTH(3*W), .DEPTH(3)) u_dly_uu3 (.clk, .en, .d_in(u_r), .d_out(u_u3));

  // ---------------- tangential part and index ratio ----------------
  logic [2:0][W-1:0]      c_r, t_r, c_nxt, t_nxt;
  logic [2*IW-1:0]        ft_t;
  logic [2:0][W+IW-1:0]   mt_r, s_dvd;
  logic [2:0]             tneg_r, s_ovf;
  logic [IW-1:0]          to_r;
  logic [2:0][W-1:0]      s_q;
  logic [5:0]             s_sb;
  logic [2:0][W-1:0]      s_r, c_s;
  logic [2:0][PW-1:0]     ss_r, cs_r;
  logic [SQW-1:0]         tt_r, cc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = fl_sat(ndn_r[i]);
      t_nxt[i] = sat_w(sx(u_u3[i]) - sx(c_nxt[i]));
    end
  end

  rrr_delay #(.WIDTH(2*IW), .DEPTH(T_T-1)) u_dly_ft (
    .clk, .en, .d_in({from1_r, to1_r}), .d_out(ft_t));

  // Quotient would not fit: clamp instead of dividing
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_ovf[i] = mt_r[i][W+IW-1:W] >= to_r;
      s_dvd[i] = s_ovf[i] ? '0 : mt_r[i];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_sdiv
    rrr_div #(.DW(IW), .QW(W)) u_div (
      .clk, .en, .dividend(s_dvd[g]), .divisor(to_r), .quotient(s_q[g]));
  end

  rrr_delay #(.WIDTH(6), .DEPTH(W)) u_dly_ssb (
    .clk, .en, .d_in({s_ovf, tneg_r}), .d_out(s_sb));
  rrr_delay #(.WIDTH(3*W), .DEPTH(T_S-T_T)) u_dly_cs (
    .clk, .en, .d_in(c_r), .d_out(c_s));

  // ---------------- new normal part ----------------
  logic [SQW-1:0]      rad;
  logic                tir_in;
  logic [LW-1:0]       root, clen;
  logic [2:0][W-1:0]   c_rr;
  logic [2:0][QDW-1:0] cu_dvd;
  logic [2:0][F:0]     cu_q;
  logic [3:0]          cu_sb_in, cu_sb;
  logic [2:0][W-1:0]   cu_r, s_cu, k_r;
  logic [LW-1:0]       root_cu, len_k;
  logic [2:0][PW2-1:0] cr_r, kl_r;

  assign tir_in = (tt_r >= ONE2);
  assign rad    = tir_in ? '0 : (ONE2 - tt_r);

  rrr_sqrt #(.IN_W(SQW)) u_sqrt_root (.clk, .en, .radicand(rad), .root(root));
  rrr_sqrt #(.IN_W(SQW)) u_sqrt_clen (.clk, .en, .radicand(cc_r), .root(clen));

  rrr_delay #(.WIDTH(3*W), .DEPTH(T_R-T_T)) u_dly_crr (
    .clk, .en, .d_in(c_r), .d_out(c_rr));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cu_dvd[i]   = QDW'({mag_w(c_rr[i]), {F{1'b0}}});
      cu_sb_in[i] = c_rr[i][W-1];
    end
    cu_sb_in[3] = (clen == '0);
  end

  for (genvar g = 0; g < 3; g++) begin : g_cdiv
    rrr_div #(.DW(LW), .QW(F+1)) u_div (
      .clk, .en, .dividend(cu_dvd[g]), .divisor(clen), .quotient(cu_q[g]));
  end

  rrr_delay #(.WIDTH(4), .DEPTH(F+1)) u_dly_cusb (
    .clk, .en, .d_in(cu_sb_in), .d_out(cu_sb));
  rrr_delay #(.WIDTH(LW), .DEPTH(T_CU-T_R)) u_dly_root (
    .clk, .en, .d_in(root), .d_out(root_cu));
  rrr_delay #(.WIDTH(3*W), .DEPTH(T_CU+1-T_S)) u_dly_scu (
    .clk, .en, .d_in(s_r), .d_out(s_cu));
  rrr_delay #(.WIDTH(LW), .DEPTH(T_CU+2-T_LEN)) u_dly_lenk (
    .clk, .en, .d_in(len), .d_out(len_k));

  // ---------------- result select ----------------
  logic              act_l, tir_l;
  logic [2:0][W-1:0] d_l, rr_l, o_r;
  logic              passed_r;

  rrr_delay #(.WIDTH(1), .DEPTH(LAT-2)) u_dly_act (
    .clk, .en, .d_in(act1_r), .d_out(act_l));
  rrr_delay #(.WIDTH(3*W), .DEPTH(LAT-1-T_LEN)) u_dly_dl (
    .clk, .en, .d_in(d_len), .d_out(d_l));
  rrr_delay #(.WIDTH(3*W), .DEPTH(LAT-5)) u_dly_rr (
    .clk, .en, .d_in(rr4_r), .d_out(rr_l));
  rrr_delay #(.WIDTH(1), .DEPTH(LAT-3-T_S)) u_dly_tir (
    .clk, .en, .d_in(tir_in), .d_out(tir_l));

  // ---------------- stage registers ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      act1_r  <= in_tuser;
      from1_r <= in_from;
      to1_r   <= (in_to == '0) ? IW'(1) : in_to;
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= in_dir[i];
        n1_r[i]  <= in_nrm[i];
        sq1_r[i] <= PW'(mag_w(in_dir[i])) * PW'(mag_w(in_dir[i]));
        dn1_r[i] <= smul(in_dir[i], $signed(in_nrm[i]));
      end

      l2_r <= SQW'(sq1_r[0]) + SQW'(sq1_r[1]) + SQW'(sq1_r[2]);
      p2_r <= dot_sat(dn1_r[0], dn1_r[1], dn1_r[2]);

      for (int i = 0; i < 3; i++) begin
        rp3_r[i] <= smul(p2_r, $signed(n2[i]));
        rr4_r[i] <= sat_w(sx(d3[i]) - (fl_x(rp3_r[i]) <<< 1));
      end

      for (int i = 0; i < 3; i++) begin
        u_r[i]   <= clamp_q(QX'(u_q[i]), u_sb[i], u_sb[3]);
        un_r[i]  <= smul(u_r[i], $signed(n_u[i]));
        ndn_r[i] <= smul(n_u2[i], $signed(dnu_r));
        c_r[i]   <= c_nxt[i];
        t_r[i]   <= t_nxt[i];
        mt_r[i]  <= (W+IW)'(mag_w(t_r[i])) * (W+IW)'(ft_t[2*IW-1:IW]);
        tneg_r[i] <= t_r[i][W-1];
      end
      dnu_r <= dot_sat(un_r[0], un_r[1], un_r[2]);
      to_r  <= ft_t[IW-1:0];

      for (int i = 0; i < 3; i++) begin
        s_r[i]  <= clamp_q(s_sb[3+i] ? HALF : QX'(s_q[i]), s_sb[i], 1'b0);
        ss_r[i] <= PW'(mag_w(s_r[i])) * PW'(mag_w(s_r[i]));
        cs_r[i] <= PW'(mag_w(c_s[i])) * PW'(mag_w(c_s[i]));
      end
      tt_r <= SQW'(ss_r[0]) + SQW'(ss_r[1]) + SQW'(ss_r[2]);
      cc_r <= SQW'(cs_r[0]) + SQW'(cs_r[1]) + SQW'(cs_r[2]);

      for (int i = 0; i < 3; i++) begin
        cu_r[i] <= clamp_q(QX'(cu_q[i]), cu_sb[i], cu_sb[3]);
        cr_r[i] <= smul(cu_r[i], {1'b0, root_cu});
        k_r[i]  <= sat_w(sx(fl_sat(cr_r[i])) + sx(s_cu[i]));
        kl_r[i] <= smul(k_r[i], {1'b0, len_k});
      end

      for (int i = 0; i < 3; i++) begin
        if (act_l == rrr_pkg::ACT_REFLECT) begin
          o_r[i] <= rr_l[i];
        end else if (tir_l) begin
          o_r[i] <= d_l[i];
        end else begin
          o_r[i] <= fl_sat(kl_r[i]);
        end
      end
      passed_r <= (act_l == rrr_pkg::ACT_REFLECT) || !tir_l;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tuser  = passed_r;

  always_comb begin
    out_tdata          = '0;
    out_tdata[3*W-1:0] = o_r;
  end

endmodule
`default_nettype wire

[hw/rtl/rrr_checker.sv]
`default_nettype none
module rrr_checker #(
  parameter int COMP_WIDTH = 24
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((3*COMP_WIDTH+7)/8)*8-1:0] out_tdata,
  input wire logic out_tuser
);

  // Pipeline is flushed by reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind ray_refract_reflect rrr_checker #(.COMP_WIDTH(COMP_WIDTH)) u_rrr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
